// ----- rtl/csse_pkg.sv -----
// Shared types, character constants and the escape helper for the
// comment stripper with string escaping. No dependencies.
`timescale 1ns / 1ps

package csse_pkg;

  // Characters that steer the scanner or appear in escape sequences
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_LOW_N = 8'h6E;
  localparam logic [7:0] CH_LOW_R = 8'h72;
  localparam logic [7:0] CH_LOW_T = 8'h74;

  // Scanner modes
  typedef enum logic [2:0] {
    MODE_NORMAL     = 3'd0,
    MODE_SLASH      = 3'd1,
    MODE_BLOCK      = 3'd2,
    MODE_BLOCK_STAR = 3'd3,
    MODE_LINE       = 3'd4
  } mode_e;

  // Escaped form of one kept byte: up to two bytes, lowest first
  typedef struct packed {
    logic [1:0][7:0] bytes;
    logic [1:0]      len;
  } esc_t;

  // Result bytes caused by one input item, lowest index first
  typedef struct packed {
    logic [2:0][7:0] bytes;
    logic [1:0]      count;
  } run_t;

  function automatic esc_t escape_byte(logic [7:0] b);
    esc_t e;
    e.bytes[0] = CH_BSLASH;
    e.bytes[1] = CH_NUL;
    e.len      = 2'd2;
    case (b)
      CH_NL:     e.bytes[1] = CH_LOW_N;
      CH_CR:     e.bytes[1] = CH_LOW_R;
      CH_TAB:    e.bytes[1] = CH_LOW_T;
      CH_DQUOTE: e.bytes[1] = CH_DQUOTE;
      CH_NUL: begin
        e.bytes[0] = CH_NUL;
        e.len      = 2'd0;
      end
      default: begin
        e.bytes[0] = b;
        e.len      = 2'd1;
      end
    endcase
    return e;
  endfunction

endpackage

// ----- rtl/comment_strip_string_escape.sv -----
// Latency: the first result byte of an item appears the cycle after it is accepted.
// Throughput: one item per cycle while each item yields at most one byte; an item yielding
// more bytes (up to three) holds off the next item until only its last byte is left.
// An item yielding no bytes waits, like any item, until at most one byte is left in the
// result buffer, and adds no stall of its own. Result-side stalls hold the input as well.
// Reset clears the comment mode to normal text and empties the result buffer.
`timescale 1ns / 1ps

module comment_strip_string_escape
  import csse_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid_i,
  output logic       s_axis_tready_o,
  input  logic [7:0] s_axis_tdata_i,   // [7:0] in_byte
  input  logic       s_axis_tlast_i,   // end_of_stream
  output logic       m_axis_tvalid_o,
  input  logic       m_axis_tready_i,
  output logic [7:0] m_axis_tdata_o,   // [7:0] out_byte
  output logic       m_axis_tlast_o    // run_last
);

  logic accept;
  logic room;
  run_t run;

  assign s_axis_tready_o = room;
  assign accept          = s_axis_tvalid_i && room;

  // Decode bytes and track comment state
  csse_scan u_scan (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (accept),
    .in_byte_i (s_axis_tdata_i),
    .eos_i     (s_axis_tlast_i),
    .run_o     (run)
  );

  // Hold and drain the run of each item
  csse_outbuf u_outbuf (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (accept && (run.count != 2'd0)),
    .run_i   (run),
    .room_o  (room),
    .valid_o (m_axis_tvalid_o),
    .ready_i (m_axis_tready_i),
    .byte_o  (m_axis_tdata_o),
    .last_o  (m_axis_tlast_o)
  );

endmodule

// ----- rtl/csse_scan.sv -----
// Scanner: holds the comment mode and decodes one input item into a run
// of up to three result bytes. Depends on csse_pkg.
`timescale 1ns / 1ps

module csse_scan
  import csse_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       accept_i,
  input  logic [7:0] in_byte_i,
  input  logic       eos_i,
  output run_t       run_o
);

  mode_e mode_q, mode_d;
  run_t  run;
  esc_t  esc;
  mode_e mode_scan;

  // Decode the byte against the current mode
  always_comb begin
    esc       = escape_byte(in_byte_i);
    run       = '0;
    mode_scan = mode_q;
    case (mode_q)
      MODE_SLASH: begin
        if (in_byte_i == CH_STAR) begin
          mode_scan = MODE_BLOCK;
        end else if (in_byte_i == CH_SLASH) begin
          mode_scan = MODE_LINE;
        end else begin
          // Release the held slash ahead of the escaped byte
          run.bytes[0] = CH_SLASH;
          run.bytes[1] = esc.bytes[0];
          run.bytes[2] = esc.bytes[1];
          run.count    = esc.len + 2'd1;
          mode_scan    = MODE_NORMAL;
        end
      end
      MODE_BLOCK: begin
        if (in_byte_i == CH_STAR) mode_scan = MODE_BLOCK_STAR;
      end
      MODE_BLOCK_STAR: begin
        if (in_byte_i == CH_SLASH) begin
          mode_scan = MODE_NORMAL;
        end else if (in_byte_i != CH_STAR) begin
          mode_scan = MODE_BLOCK;
        end
      end
      MODE_LINE: begin
        if (in_byte_i == CH_NL) begin
          run.bytes[0] = esc.bytes[0];
          run.bytes[1] = esc.bytes[1];
          run.count    = esc.len;
          mode_scan    = MODE_NORMAL;
        end
      end
      default: begin
        if (in_byte_i == CH_SLASH) begin
          mode_scan = MODE_SLASH;
        end else begin
          run.bytes[0] = esc.bytes[0];
          run.bytes[1] = esc.bytes[1];
          run.count    = esc.len;
          mode_scan    = MODE_NORMAL;
        end
      end
    endcase

    // End of stream: flush a held slash and restart in normal text
    mode_d = mode_scan;
    if (eos_i) begin
      if (mode_scan == MODE_SLASH) begin
        run.bytes[0] = CH_SLASH;
        run.count    = 2'd1;
      end
      mode_d = MODE_NORMAL;
    end
  end

  assign run_o = run;

  // Advance the mode on each accepted item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_NORMAL;
    end else if (accept_i) begin
      mode_q <= mode_d;
    end
  end

`ifndef NO_ASSERTIONS
  // A final byte always leaves the scanner in normal text
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept_i && eos_i) |=> (mode_q == MODE_NORMAL))
    else $error("mode not normal after end of stream");

  // Three result bytes only come from releasing a held slash
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (run.count == 2'd3) |-> (mode_q == MODE_SLASH))
    else $error("three-byte run outside slash mode");

  // Nothing is emitted while inside a block comment
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mode_q == MODE_BLOCK || mode_q == MODE_BLOCK_STAR) |-> (run.count == 2'd0))
    else $error("output produced inside block comment");
`endif

endmodule

// ----- rtl/csse_outbuf.sv -----
// Result buffer: holds the run of one item and hands its bytes out one
// per cycle while ready_i holds, marking the last. Depends on csse_pkg.
`timescale 1ns / 1ps

module csse_outbuf
  import csse_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       load_i,
  input  run_t       run_i,
  output logic       room_o,
  output logic       valid_o,
  input  logic       ready_i,
  output logic [7:0] byte_o,
  output logic       last_o
);

  logic [2:0][7:0] slot_q, slot_d;
  logic [1:0]      cnt_q, cnt_d;
  logic            pop;

  assign pop     = valid_o && ready_i;
  assign valid_o = (cnt_q != 2'd0);
  assign byte_o  = slot_q[0];
  assign last_o  = (cnt_q == 2'd1);
  // Take a new run when empty or emptying this cycle
  assign room_o  = (cnt_q == 2'd0) || (cnt_q == 2'd1 && ready_i);

  // Load a fresh run, or shift one byte out
  always_comb begin
    slot_d = slot_q;
    cnt_d  = cnt_q;
    if (load_i) begin
      slot_d = run_i.bytes;
      cnt_d  = run_i.count;
    end else if (pop) begin
      slot_d[0] = slot_q[1];
      slot_d[1] = slot_q[2];
      cnt_d     = cnt_q - 2'd1;
    end else if (room_o) begin
      cnt_d = cnt_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    slot_q <= slot_d;
  end

`ifndef NO_ASSERTIONS
  // A load never overwrites bytes still to be delivered
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_i |-> (cnt_q == 2'd0 || (cnt_q == 2'd1 && pop)))
    else $error("run loaded over pending bytes");

  // A pop within a run presents the following byte next
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && cnt_q > 2'd1 && !load_i) |=> (byte_o == $past(slot_q[1])))
    else $error("run bytes out of order");

  // The count drops by exactly one on a pop within a run
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && !load_i) |=> (cnt_q == $past(cnt_q) - 2'd1))
    else $error("run count did not step down");
`endif

endmodule
